### rtl/bsa_pkg.sv
// Package for the batch sorter: defaults, state codes and the cell link type.
// No dependencies.
package bsa_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    // what one cell tells its neighbors
    typedef struct packed {
        logic valid;   // cell holds an element
        logic gt;      // cell holds nothing or a value above the one being inserted
    } t_cell_ctl;

endpackage

### rtl/bsa_in_if.sv
// Input channel of the batch sorter: valid/ready with value and last_item.
// No dependencies.
interface bsa_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

### rtl/bsa_out_if.sv
// Output channel of the batch sorter: valid/ready with the sorted result fields.
// No dependencies.
interface bsa_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_result;
    logic                         dropped;

    modport source (output valid, output sorted_value, output last_result,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input last_result,
                    input dropped, output ready);
endinterface

### rtl/bsa_cell.sv
// One compare-and-insert cell of the sorting chain.
// Depends on bsa_pkg.
module bsa_cell #(
    parameter int DATA_WIDTH = bsa_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_insert,
    input  logic                         i_shift,
    input  logic signed [DATA_WIDTH-1:0] i_new_value,
    input  bsa_pkg::t_cell_ctl           i_prev_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_prev_value,
    input  bsa_pkg::t_cell_ctl           i_next_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_next_value,
    output bsa_pkg::t_cell_ctl           o_ctl,
    output logic signed [DATA_WIDTH-1:0] o_value
);
    import bsa_pkg::*;

    logic                         r_valid;
    logic                         n_valid;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic signed [DATA_WIDTH-1:0] n_value;
    logic                         w_gt;

    // strict compare keeps a new value behind equal ones already held
    assign w_gt = !r_valid || (r_value > i_new_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_shift) begin
            n_valid = i_next_ctl.valid;
            n_value = i_next_value;
        end else if (i_insert && w_gt) begin
            if (i_prev_ctl.gt) begin
                n_valid = i_prev_ctl.valid;
                n_value = i_prev_value;
            end else begin
                n_valid = 1'b1;
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.gt    = w_gt;
    assign o_value     = r_value;

endmodule

### rtl/batch_sort_ascending.sv
// Top level of the batch sorter: control and a chain of DEPTH insert cells.
// Depends on bsa_pkg, bsa_in_if, bsa_out_if and bsa_cell.
//
//  channel | dir | fields                               | accepted when
//  i_in    | in  | value, last_item                     | valid & ready
//  o_out   | out | sorted_value, last_result, dropped   | valid & ready
//
// Fill: one item per cycle; each value is registered into its sorted place in the
// cell chain (broadcast compare, shift by one toward the tail).
// Drain: after last_item the chain shifts toward cell 0, one result per cycle
// while o_out.ready is high, and i_in is not ready until the last result is
// taken. Values arriving with the chain full are dropped.
// Reset (synchronous, active low) empties every cell and returns to fill.
module batch_sort_ascending #(
    parameter int DEPTH      = bsa_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsa_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsa_in_if.sink    i_in,
    bsa_out_if.source o_out
);
    import bsa_pkg::*;

    t_state                       r_state;
    t_state                       n_state;
    logic                         r_ovf;
    logic                         n_ovf;

    t_cell_ctl                    w_ctl   [DEPTH];
    logic signed [DATA_WIDTH-1:0] w_value [DEPTH];

    logic w_in_acc;
    logic w_out_acc;
    logic w_full;
    logic w_insert;
    logic w_shift;
    logic w_tail_out;

    assign w_full     = w_ctl[DEPTH-1].valid;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_insert   = w_in_acc && !w_full;
    assign w_shift    = w_out_acc;
    assign w_tail_out = w_out_acc && o_out.last_result;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_cell_ctl                    w_prev_ctl;
            logic signed [DATA_WIDTH-1:0] w_prev_value;
            t_cell_ctl                    w_next_ctl;
            logic signed [DATA_WIDTH-1:0] w_next_value;

            if (g == 0) begin : g_head
                assign w_prev_ctl   = '0;
                assign w_prev_value = '0;
            end else begin : g_mid_prev
                assign w_prev_ctl   = w_ctl[g-1];
                assign w_prev_value = w_value[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_ctl   = '0;
                assign w_next_value = '0;
            end else begin : g_mid_next
                assign w_next_ctl   = w_ctl[g+1];
                assign w_next_value = w_value[g+1];
            end

            bsa_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_insert     (w_insert),
                .i_shift      (w_shift),
                .i_new_value  (i_in.value),
                .i_prev_ctl   (w_prev_ctl),
                .i_prev_value (w_prev_value),
                .i_next_ctl   (w_next_ctl),
                .i_next_value (w_next_value),
                .o_ctl        (w_ctl[g]),
                .o_value      (w_value[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc && w_full) begin
                    n_ovf = 1'b1;
                end
                if (w_in_acc && i_in.last_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_tail_out) begin
                    n_state = ST_FILL;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    assign i_in.ready         = (r_state == ST_FILL);
    assign o_out.valid        = (r_state == ST_DRAIN) && w_ctl[0].valid;
    assign o_out.sorted_value = w_value[0];
    assign o_out.last_result  = !w_ctl[1].valid;
    assign o_out.dropped      = r_ovf;

    // never take input while results are going out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready during drain");

    // the last item of a batch always starts a drain with a result ready
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_item) |=> o_out.valid)
        else $error("no result after last item");

    // after the final result the chain is empty and input resumes
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_result)
            |=> (i_in.ready && !o_out.valid && !r_ovf))
        else $error("chain not empty after final result");

    // cell 1 holds a value only if cell 0 does: no gap at the head of the chain
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[1].valid |-> w_ctl[0].valid)
        else $error("gap at head of chain");

endmodule
